// File: hw/rtl/uart_baud_divisor_calc_top_macros.svh
// Assertion macros for the baud divisor calculator.
`ifndef UART_BAUD_DIVISOR_CALC_TOP_MACROS_SVH
`define UART_BAUD_DIVISOR_CALC_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define UBD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Plain invariant, checked outside reset.
`define UBD_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

// File: hw/rtl/ubd_pkg.sv
// Package: widths, constants and clock-tree helpers for the baud divisor calculator.
`default_nettype none
package ubd_pkg;

    localparam int BAUD_W      = 24;
    localparam int PCLK_W      = 28;
    localparam int CFG_W       = 32;
    localparam int MANT_W      = 24;
    localparam int FRAC_W      = 4;
    localparam int WORD_W      = 16;
    localparam int DIV_NUM_W   = 32;
    localparam int DIV_STEPS   = 4;
    localparam int DIV_STAGES  = DIV_NUM_W / DIV_STEPS;
    localparam int PIPE_DEPTH  = DIV_STAGES + 5;

    localparam logic [1:0]        PLL_SEL       = 2'd2;
    localparam logic [PCLK_W-1:0] OSC_HZ        = 28'd8000000;
    localparam logic [PCLK_W-1:0] HALF_OSC_HZ   = 28'd4000000;
    localparam logic [31:0]       DIV100_MAGIC  = 32'h51EB851F;
    localparam int                DIV100_SHIFT  = 37;
    localparam logic [12:0]       FRAC_MAGIC    = 13'd5243;
    localparam int                FRAC_SHIFT    = 19;
    localparam logic [6:0]        PCT           = 7'd100;
    localparam logic [10:0]       FRAC_BIAS     = 11'd50;
    localparam logic [4:0]        FRAC_FULL     = 5'd16;

    typedef struct packed {
        logic [BAUD_W-1:0]    rem;
        logic [DIV_NUM_W-1:0] nq;
        logic [BAUD_W-1:0]    baud;
        logic [PCLK_W-1:0]    pclk;
        logic                 err;
    } t_div_slot;

    function automatic logic [3:0] ahb_shift(input logic [3:0] code);
        logic [3:0] sh;
        case (code)
            4'd8:    sh = 4'd1;
            4'd9:    sh = 4'd2;
            4'd10:   sh = 4'd3;
            4'd11:   sh = 4'd4;
            4'd12:   sh = 4'd6;
            4'd13:   sh = 4'd7;
            4'd14:   sh = 4'd8;
            4'd15:   sh = 4'd9;
            default: sh = 4'd0;
        endcase
        return sh;
    endfunction

    function automatic logic [2:0] apb_shift(input logic [2:0] code);
        logic [2:0] sh;
        sh = code[2] ? ({1'b0, code[1:0]} + 3'd1) : 3'd0;
        return sh;
    endfunction

    function automatic logic [PCLK_W-1:0] bus_clock(input logic [CFG_W-1:0] cfg);
        logic [5:0]        factor;
        logic [33:0]       prod;
        logic [3:0]        sh;
        if (cfg[3:2] == PLL_SEL) begin
            factor = ({2'b00, cfg[21:18]} + 6'd2) << cfg[16];
        end else begin
            factor = 6'd2;
        end
        prod = 34'(HALF_OSC_HZ) * 34'(factor);
        sh   = ahb_shift(cfg[7:4]) + {1'b0, apb_shift(cfg[13:11])};
        return prod[PCLK_W-1:0] >> sh;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ubd_div_stage.sv
// One registered stage of the restoring divider: DIV_STEPS quotient bits per cycle.
`default_nettype none
module ubd_div_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire ubd_pkg::t_div_slot i_slot,
    output logic                    o_valid,
    output ubd_pkg::t_div_slot      o_slot
);
    import ubd_pkg::*;

    t_div_slot      n_slot;
    logic           r_valid;
    t_div_slot      r_slot;

    always_comb begin
        logic [BAUD_W:0] t;
        n_slot = i_slot;
        for (int k = 0; k < DIV_STEPS; k++) begin
            t = {n_slot.rem, n_slot.nq[DIV_NUM_W-1]};
            n_slot.nq = {n_slot.nq[DIV_NUM_W-2:0], 1'b0};
            if (t >= {1'b0, n_slot.baud}) begin
                t = t - {1'b0, n_slot.baud};
                n_slot.nq[0] = 1'b1;
            end
            n_slot.rem = t[BAUD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_valid = r_valid;
    assign o_slot  = r_slot;

endmodule
`default_nettype wire

// File: hw/rtl/uart_baud_divisor_calc_top.sv
// Top level: fractional baud divisor calculator, fully pipelined.
// Usage:
//   Config channel (i_cfg_valid/o_cfg_ready/i_cfg_data) loads the clock control
//   word; ready is always high. Write it only while no item is in flight. The
//   bus clock is derived at write time and held in a register.
//   Command channel: an item is taken at a clock edge with i_start high and
//   o_busy low. o_busy is always low, so one item can enter every cycle.
//   Results pass through the input register, the 8-stage divider (4 quotient
//   bits per stage) and the mantissa, remainder, fraction and output registers;
//   each appears for one cycle, marked by o_valid, and is taken at the edge
//   ending that cycle.
//   Throughput: one item per cycle. The receiver cannot stall the block.
//   Zero baud rate gives o_baud_error high and all other fields zero.
//   Reset (synchronous, active low) sets the bus clock to 8 MHz, as for a zero
//   config word, and drops all items in flight.
`default_nettype none
module uart_baud_divisor_calc_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    output logic                                o_busy,
    input  wire logic [ubd_pkg::BAUD_W-1:0]     i_baud_rate,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [ubd_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                                o_valid,
    output logic [ubd_pkg::MANT_W-1:0]          o_divisor_mantissa,
    output logic [ubd_pkg::FRAC_W-1:0]          o_divisor_fraction,
    output logic [ubd_pkg::WORD_W-1:0]          o_divisor_word,
    output logic [ubd_pkg::PCLK_W-1:0]          o_bus_clock_hz,
    output logic                                o_baud_error
);
    import ubd_pkg::*;

    logic [PCLK_W-1:0]    r_pclk;
    logic                 r_in_vld;
    t_div_slot            r_in_slot;
    logic [29:0]          n_num;
    logic [31:0]          w_num_full;

    logic                 w_vld  [0:DIV_STAGES];
    t_div_slot            w_slot [0:DIV_STAGES];

    logic                 r_m_vld;
    logic [MANT_W-1:0]    r_m_mant;
    logic [29:0]          r_m_q;
    logic [PCLK_W-1:0]    r_m_pclk;
    logic                 r_m_err;
    logic [63:0]          n_m_prod;

    logic                 r_r_vld;
    logic [MANT_W-1:0]    r_r_mant;
    logic [6:0]           r_r_rem;
    logic [PCLK_W-1:0]    r_r_pclk;
    logic                 r_r_err;
    logic [30:0]          n_r_diff;

    logic                 r_f_vld;
    logic [MANT_W-1:0]    r_f_mant;
    logic [4:0]           r_f_frac;
    logic [PCLK_W-1:0]    r_f_pclk;
    logic                 r_f_err;
    logic [10:0]          n_f_scaled;
    logic [23:0]          n_f_prod;

    logic                 r_o_vld;
    logic [MANT_W-1:0]    r_o_mant;
    logic [FRAC_W-1:0]    r_o_frac;
    logic [WORD_W-1:0]    r_o_word;
    logic [PCLK_W-1:0]    r_o_pclk;
    logic                 r_o_err;
    logic [MANT_W-1:0]    n_o_mant;
    logic [FRAC_W-1:0]    n_o_frac;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pclk <= OSC_HZ;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_pclk <= bus_clock(i_cfg_data);
        end
    end

    // 25*pclk/4, floor
    assign w_num_full = ({4'b0, r_pclk} << 4) + ({4'b0, r_pclk} << 3) + {4'b0, r_pclk};
    assign n_num      = w_num_full[31:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_slot.rem  <= '0;
        r_in_slot.nq   <= {2'b00, n_num};
        r_in_slot.baud <= i_baud_rate;
        r_in_slot.pclk <= r_pclk;
        r_in_slot.err  <= (i_baud_rate == '0);
    end

    assign w_vld[0]  = r_in_vld;
    assign w_slot[0] = r_in_slot;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        ubd_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[g]),
            .i_slot  (w_slot[g]),
            .o_valid (w_vld[g+1]),
            .o_slot  (w_slot[g+1])
        );
    end

    // mantissa = q / 100 by reciprocal
    assign n_m_prod = 64'(w_slot[DIV_STAGES].nq) * 64'(DIV100_MAGIC);

    always_ff @(posedge i_clk) begin
        r_m_mant <= n_m_prod[DIV100_SHIFT+MANT_W-1:DIV100_SHIFT];
        r_m_q    <= w_slot[DIV_STAGES].nq[29:0];
        r_m_pclk <= w_slot[DIV_STAGES].pclk;
        r_m_err  <= w_slot[DIV_STAGES].err;
    end

    assign n_r_diff = {1'b0, r_m_q} - 31'(31'(r_m_mant) * 31'(PCT));

    always_ff @(posedge i_clk) begin
        r_r_mant <= r_m_mant;
        r_r_rem  <= n_r_diff[6:0];
        r_r_pclk <= r_m_pclk;
        r_r_err  <= r_m_err;
    end

    // (rem*16 + 50) / 100 by reciprocal
    assign n_f_scaled = {r_r_rem, 4'b0000} + FRAC_BIAS;
    assign n_f_prod   = 24'(n_f_scaled) * 24'(FRAC_MAGIC);

    always_ff @(posedge i_clk) begin
        r_f_mant <= r_r_mant;
        r_f_frac <= n_f_prod[FRAC_SHIFT+4:FRAC_SHIFT];
        r_f_pclk <= r_r_pclk;
        r_f_err  <= r_r_err;
    end

    always_comb begin
        if (r_f_frac == FRAC_FULL) begin
            n_o_mant = r_f_mant + MANT_W'(1);
            n_o_frac = '0;
        end else begin
            n_o_mant = r_f_mant;
            n_o_frac = r_f_frac[FRAC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_f_err) begin
            r_o_mant <= '0;
            r_o_frac <= '0;
            r_o_word <= '0;
            r_o_pclk <= '0;
        end else begin
            r_o_mant <= n_o_mant;
            r_o_frac <= n_o_frac;
            r_o_word <= {n_o_mant[WORD_W-FRAC_W-1:0], n_o_frac};
            r_o_pclk <= r_f_pclk;
        end
        r_o_err <= r_f_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_r_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_m_vld <= w_vld[DIV_STAGES];
            r_r_vld <= r_m_vld;
            r_f_vld <= r_r_vld;
            r_o_vld <= r_f_vld;
        end
    end

    assign o_valid            = r_o_vld;
    assign o_divisor_mantissa = r_o_mant;
    assign o_divisor_fraction = r_o_frac;
    assign o_divisor_word     = r_o_word;
    assign o_bus_clock_hz     = r_o_pclk;
    assign o_baud_error       = r_o_err;

    `include "uart_baud_divisor_calc_top_macros.svh"

    `UBD_ASSERT_IMPL(a_err_zeroes, i_clk, i_rst_n, o_valid && o_baud_error,
        (o_divisor_word == '0) && (o_bus_clock_hz == '0) && (o_divisor_mantissa == '0),
        "error result carries nonzero fields")
    `UBD_ASSERT_IMPL(a_strobe_origin, i_clk, i_rst_n, o_valid,
        $past(i_start && !o_busy, PIPE_DEPTH),
        "result strobe without a matching accepted item")
    `UBD_ASSERT_IMPL(a_word_packing, i_clk, i_rst_n, o_valid && !o_baud_error,
        (o_bus_clock_hz != '0) &&
        (o_divisor_word[WORD_W-1:FRAC_W] == o_divisor_mantissa[WORD_W-FRAC_W-1:0]),
        "divisor word or bus clock inconsistent")

endmodule
`default_nettype wire

// File: sim/uart_baud_divisor_calc_top_tb.sv
// Testbench: baud divisor calculator checked against a predictor over directed and random items.
`default_nettype none
module uart_baud_divisor_calc_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ubd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned DRAIN_CYCLES = 20;

    typedef struct {
        bit                is_cfg;
        logic [CFG_W-1:0]  data;
        int unsigned       idle_pct;
    } t_command;

    typedef struct packed {
        logic [MANT_W-1:0] mantissa;
        logic [FRAC_W-1:0] fraction;
        logic [WORD_W-1:0] word;
        logic [PCLK_W-1:0] bus_clock;
        logic              error;
    } t_divisor;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_start = 1'b0;
    logic [BAUD_W-1:0]   i_baud_rate = '0;
    logic                i_cfg_valid = 1'b0;
    logic [CFG_W-1:0]    i_cfg_data = '0;
    logic                o_busy;
    logic                o_cfg_ready;
    logic                o_valid;
    logic [MANT_W-1:0]   o_divisor_mantissa;
    logic [FRAC_W-1:0]   o_divisor_fraction;
    logic [WORD_W-1:0]   o_divisor_word;
    logic [PCLK_W-1:0]   o_bus_clock_hz;
    logic                o_baud_error;

    t_command            pending_cmds[$];
    t_divisor            expected_divisors[$];
    logic [CFG_W-1:0]    clock_word = '0;
    int unsigned         error_count = 0;
    int unsigned         cycle_count = 0;

    uart_baud_divisor_calc_top u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .o_busy             (o_busy),
        .i_baud_rate        (i_baud_rate),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .o_valid            (o_valid),
        .o_divisor_mantissa (o_divisor_mantissa),
        .o_divisor_fraction (o_divisor_fraction),
        .o_divisor_word     (o_divisor_word),
        .o_bus_clock_hz     (o_bus_clock_hz),
        .o_baud_error       (o_baud_error)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_divisor predict_divisor(input logic [CFG_W-1:0] cw,
                                                 input logic [BAUD_W-1:0] baud);
        t_divisor    d;
        logic [63:0] sys_hz;
        logic [63:0] pclk;
        logic [63:0] scaled;
        logic [63:0] mant;
        logic [63:0] rem;
        logic [63:0] frac;
        int unsigned ahb;
        int unsigned apb;
        d = '0;
        if (baud == '0) begin
            d.error = 1'b1;
            return d;
        end
        sys_hz = 64'd8000000;
        if (cw[3:2] == PLL_SEL) begin
            sys_hz = (cw[16] ? 64'd8000000 : 64'd4000000) * (64'(cw[21:18]) + 64'd2);
        end
        // AHB: 8..11 -> 2..16, 12..15 -> 64..512 (no divide by 32)
        ahb = !cw[7] ? 1 : ((cw[6:4] < 3'd4) ? (2 << cw[6:4]) : (4 << cw[6:4]));
        apb = cw[13] ? (2 << cw[12:11]) : 1;
        pclk   = sys_hz / ahb / apb;
        scaled = (64'd25 * pclk) / (64'd4 * 64'(baud));
        mant   = scaled / 64'd100;
        rem    = scaled - mant * 64'd100;
        frac   = (rem * 64'd16 + 64'd50) / 64'd100;
        if (frac > 64'd15) begin
            mant = mant + 64'd1;
            frac = 64'd0;
        end
        d.mantissa  = mant[MANT_W-1:0];
        d.fraction  = frac[FRAC_W-1:0];
        d.word      = WORD_W'((mant << 4) | frac);
        d.bus_clock = pclk[PCLK_W-1:0];
        return d;
    endfunction

    task automatic add_config(input logic [CFG_W-1:0] cw, input int unsigned idle);
        t_command c;
        c.is_cfg   = 1'b1;
        c.data     = cw;
        c.idle_pct = idle;
        pending_cmds.push_back(c);
    endtask

    task automatic add_item(input logic [BAUD_W-1:0] baud, input int unsigned idle);
        t_command c;
        c.is_cfg   = 1'b0;
        c.data     = CFG_W'(baud);
        c.idle_pct = idle;
        pending_cmds.push_back(c);
    endtask

    function automatic logic [BAUD_W-1:0] random_baud();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 4) begin
            return '0;
        end else if (pick < 30) begin
            return BAUD_W'($urandom_range(1023, 1));
        end else if (pick < 70) begin
            return BAUD_W'($urandom_range(4000000, 300));
        end
        return BAUD_W'($urandom);
    endfunction

    function automatic logic [CFG_W-1:0] random_clock_word();
        logic [CFG_W-1:0] cw;
        cw = $urandom;
        if ($urandom_range(1) == 1) begin
            cw[3:2] = PLL_SEL;
        end
        return cw;
    endfunction

    // driver: items and config writes, config only once the pipe has drained
    always @(posedge i_clk) begin
        t_command         head;
        logic             nxt_start;
        logic             nxt_cfg_valid;
        logic [BAUD_W-1:0] nxt_baud;
        logic [CFG_W-1:0] nxt_cfg_data;
        nxt_start     = i_start;
        nxt_cfg_valid = i_cfg_valid;
        nxt_baud      = i_baud_rate;
        nxt_cfg_data  = i_cfg_data;
        if (!i_rst_n) begin
            nxt_start     = 1'b0;
            nxt_cfg_valid = 1'b0;
            clock_word    = '0;
        end else begin
            if (i_start && !o_busy) begin
                expected_divisors.push_back(predict_divisor(clock_word, i_baud_rate));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                clock_word = i_cfg_data;
            end
            if (!((i_start && o_busy) || (i_cfg_valid && !o_cfg_ready))) begin
                nxt_start     = 1'b0;
                nxt_cfg_valid = 1'b0;
                nxt_baud      = BAUD_W'($urandom);
                if (pending_cmds.size() != 0) begin
                    head = pending_cmds[0];
                    if (head.is_cfg) begin
                        if (expected_divisors.size() == 0 && !i_start) begin
                            void'(pending_cmds.pop_front());
                            nxt_cfg_valid = 1'b1;
                            nxt_cfg_data  = head.data;
                        end
                    end else if ($urandom_range(99) >= head.idle_pct) begin
                        void'(pending_cmds.pop_front());
                        nxt_start = 1'b1;
                        nxt_baud  = head.data[BAUD_W-1:0];
                    end
                end
            end
        end
        i_start     <= nxt_start;
        i_cfg_valid <= nxt_cfg_valid;
        i_baud_rate <= nxt_baud;
        i_cfg_data  <= nxt_cfg_data;
    end

    // monitor: compare each result with the oldest prediction
    always @(posedge i_clk) begin
        t_divisor exp_d;
        if (i_rst_n && o_valid) begin
            if (expected_divisors.size() == 0) begin
                $error("unexpected result: mantissa %0d", o_divisor_mantissa);
                error_count++;
            end else begin
                exp_d = expected_divisors.pop_front();
                if (o_divisor_mantissa !== exp_d.mantissa) begin
                    $error("divisor_mantissa: expected %0d, got %0d",
                           exp_d.mantissa, o_divisor_mantissa);
                    error_count++;
                end
                if (o_divisor_fraction !== exp_d.fraction) begin
                    $error("divisor_fraction: expected %0d, got %0d",
                           exp_d.fraction, o_divisor_fraction);
                    error_count++;
                end
                if (o_divisor_word !== exp_d.word) begin
                    $error("divisor_word: expected %0d, got %0d", exp_d.word, o_divisor_word);
                    error_count++;
                end
                if (o_bus_clock_hz !== exp_d.bus_clock) begin
                    $error("bus_clock_hz: expected %0d, got %0d",
                           exp_d.bus_clock, o_bus_clock_hz);
                    error_count++;
                end
                if (o_baud_error !== exp_d.error) begin
                    $error("baud_error: expected %0d, got %0d", exp_d.error, o_baud_error);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("uart_baud_divisor_calc_top_tb: errors");
            $finish;
        end
    end

    initial begin
        int unsigned idle_plan[3];
        idle_plan = '{35, 70, 0};

        // reset config word (8 MHz bus clock)
        add_item('0, 35);
        add_item(24'd1, 35);
        add_item(24'hFFFFFF, 35);
        add_item(24'd9600, 35);
        add_item(24'd115200, 35);
        add_item(24'd4951, 35);   // fraction rounds up to sixteen
        add_item(24'd3, 35);
        // fastest bus clock: PLL 8 MHz x 17, no prescale
        add_config(32'h003D0008, 35);
        add_item(24'd1, 35);
        add_item(24'hFFFFFF, 35);
        add_item('0, 35);
        add_item(24'd115200, 35);
        add_item(24'd4500000, 35);
        // all ones: 8 MHz through the largest prescalers
        add_config(32'hFFFFFFFF, 35);
        add_item(24'd1, 35);
        add_item(24'd976, 35);
        add_item(24'hFFFFFF, 35);
        add_item(24'd300, 35);
        // PLL 4 MHz x 2 with AHB /64 and APB /2
        add_config(32'h000020C8, 35);
        add_item(24'd9600, 35);
        add_item(24'd1, 35);

        foreach (idle_plan[p]) begin
            for (int s = 0; s < 6; s++) begin
                add_config(random_clock_word(), idle_plan[p]);
                for (int n = 0; n < 72; n++) begin
                    add_item(random_baud(), idle_plan[p]);
                end
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || i_start || i_cfg_valid ||
               expected_divisors.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("uart_baud_divisor_calc_top_tb: clean");
        end else begin
            $display("uart_baud_divisor_calc_top_tb: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
